// ===== rtl/spq_pkg.sv =====
// Package for the shift-register priority queue: sizes, command and status
// codes, and the per-cell control word. No dependencies.
`timescale 1ns / 1ps

package spq_pkg;

   localparam int DEPTH   = 8;
   localparam int KEY_W   = 32;
   localparam int OCC_W   = $clog2(DEPTH + 1);
   localparam int COUNT_W = 4;

   localparam logic CMD_ENQ = 1'b0;
   localparam logic CMD_DEQ = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   // shift command broadcast to every cell of the row
   typedef struct packed {
      logic enq;
      logic deq;
   } spq_ctl_type;

endpackage

// ===== rtl/sorted_array_priority_queue_core.sv =====
// Shift-register min-priority queue of DEPTH signed 32-bit keys.
// The response word for a command is registered and appears in the cycle after start.
// Throughput: one command per cycle; busy is never raised, each cell does its
// compare and shift in the same cycle.
// Reset clears the occupancy and the response strobe; key cells are not reset.
// The receiver cannot stall: each response word is shown for one cycle only.
`timescale 1ns / 1ps

module sorted_array_priority_queue_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_cmd,
   input  logic signed [spq_pkg::KEY_W-1:0]     req_value,
   output logic                                 rsp_valid,
   output logic [1:0]                           rsp_status,
   output logic signed [spq_pkg::KEY_W-1:0]     rsp_out_value,
   output logic [spq_pkg::COUNT_W-1:0]          rsp_count,
   output logic                                 rsp_is_empty,
   output logic                                 rsp_is_full
);
   import spq_pkg::*;

   // occupancy and response registers
   logic [OCC_W-1:0]        occ_ff, occ_in;
   logic                    rsp_valid_ff;
   logic [1:0]              rsp_status_ff, rsp_status_in;
   logic signed [KEY_W-1:0] rsp_value_ff, rsp_value_in;
   logic [COUNT_W-1:0]      rsp_count_ff;
   logic                    rsp_empty_ff, rsp_full_ff;

   logic                    accept;
   logic                    is_full_now, is_empty_now;
   spq_ctl_type             ctl;

   // row wiring
   logic signed [KEY_W-1:0] cell_value [DEPTH];
   logic                    cell_take  [DEPTH];

   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign is_full_now  = (occ_ff == OCC_W'(DEPTH));
   assign is_empty_now = (occ_ff == '0);

   assign ctl.enq = accept && (req_cmd == CMD_ENQ) && !is_full_now;
   assign ctl.deq = accept && (req_cmd == CMD_DEQ) && !is_empty_now;

   // the row: cell 0 holds the smallest key
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                    left_take;
      logic signed [KEY_W-1:0] left_value;
      logic signed [KEY_W-1:0] right_value;

      if (i == 0) begin : g_first
         assign left_take  = 1'b0;
         assign left_value = cell_value[0];
      end else begin : g_mid
         assign left_take  = cell_take[i-1];
         assign left_value = cell_value[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_value = cell_value[i];
      end else begin : g_inner
         assign right_value = cell_value[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .key         (req_value),
         .held        (OCC_W'(i) < occ_ff),
         .left_take   (left_take),
         .left_value  (left_value),
         .right_value (right_value),
         .take        (cell_take[i]),
         .value       (cell_value[i])
      );
   end

   // next occupancy and response word
   always_comb begin
      occ_in        = occ_ff;
      rsp_status_in = STATUS_OK;
      rsp_value_in  = '0;
      if (req_cmd == CMD_ENQ) begin
         if (is_full_now) begin
            rsp_status_in = STATUS_FULL;
         end else begin
            occ_in = occ_ff + OCC_W'(1);
         end
      end else begin
         if (is_empty_now) begin
            rsp_status_in = STATUS_EMPTY;
         end else begin
            occ_in       = occ_ff - OCC_W'(1);
            rsp_value_in = cell_value[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= accept;
         if (accept) begin
            occ_ff <= occ_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= rsp_status_in;
         rsp_value_ff  <= rsp_value_in;
         rsp_count_ff  <= COUNT_W'(occ_in);
         rsp_empty_ff  <= (occ_in == '0);
         rsp_full_ff   <= (occ_in == OCC_W'(DEPTH));
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_count     = rsp_count_ff;
   assign rsp_is_empty  = rsp_empty_ff;
   assign rsp_is_full   = rsp_full_ff;

   // every accepted command yields a response word next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("response word missing after accepted command");

   // occupancy stays within the row
   a_occ_range: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(DEPTH))
      else $error("occupancy beyond depth");

   // rejected commands return no key
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STATUS_OK)) |-> (rsp_out_value == '0))
      else $error("rejected command returned a key");

   // the two lowest held keys stay in order
   a_sorted_head: assert property (@(posedge clock) disable iff (reset)
      (occ_ff >= OCC_W'(2)) |-> (cell_value[0] <= cell_value[1]))
      else $error("head of row out of order");

endmodule

// ===== rtl/spq_cell.sv =====
// One cell of the sorted row: holds one key, compares it with the incoming
// key and shifts up or down with its neighbours. Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_cell (
   input  logic                               clock,
   input  spq_pkg::spq_ctl_type               ctl,
   input  logic signed [spq_pkg::KEY_W-1:0]   key,
   input  logic                               held,
   input  logic                               left_take,
   input  logic signed [spq_pkg::KEY_W-1:0]   left_value,
   input  logic signed [spq_pkg::KEY_W-1:0]   right_value,
   output logic                               take,
   output logic signed [spq_pkg::KEY_W-1:0]   value
);
   import spq_pkg::*;

   logic signed [KEY_W-1:0] value_ff;
   logic signed [KEY_W-1:0] value_in;

   // empty cells and cells at or above the key make room for it
   assign take = !held || (value_ff >= key);

   always_comb begin
      value_in = value_ff;
      if (ctl.enq) begin
         if (left_take) begin
            value_in = left_value;
         end else if (take) begin
            value_in = key;
         end
      end else if (ctl.deq) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

// ===== bench/tb_sorted_array_priority_queue_core.sv =====
// Self-checking bench for sorted_array_priority_queue_core: directed table, then biased random
// enqueue/dequeue traffic checked against an in-bench sorted-array predictor.
// Depends on rtl/spq_pkg.sv and rtl/sorted_array_priority_queue_core.sv.
`timescale 1ns / 1ps

module tb_sorted_array_priority_queue_core;
   import spq_pkg::*;

   localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
   localparam int RANDOM_WORDS = 1230;
   localparam int QUIET_FROM   = 1030;   // no idling from here to the end
   localparam int PAUSE_AT     = 600;    // sender waits for every response here

   // one response word as seen on the rsp_ ports
   typedef struct packed {
      logic [1:0]               status;
      logic signed [KEY_W-1:0]  out_value;
      logic [COUNT_W-1:0]       count;
      logic                     is_empty;
      logic                     is_full;
   } rsp_word_type;

   // directed row: command, key, and an optional hand-written response
   typedef struct packed {
      logic                     cmd;
      logic signed [KEY_W-1:0]  key;
      logic                     typed;
      rsp_word_type             want;
   } dir_row_type;

   typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} traffic_mix_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic                     req_cmd = CMD_ENQ;
   logic signed [KEY_W-1:0]  req_value = '0;
   logic                     rsp_valid;
   logic [1:0]               rsp_status;
   logic signed [KEY_W-1:0]  rsp_out_value;
   logic [COUNT_W-1:0]       rsp_count;
   logic                     rsp_is_empty;
   logic                     rsp_is_full;

   // predictor state: keys packed from cell 0, ascending
   logic signed [KEY_W-1:0]  model_keys [DEPTH];
   int                       model_fill = 0;

   rsp_word_type             pending_words [$];
   int                       mismatches = 0;
   int                       n_enq = 0;
   int                       n_deq = 0;
   int                       n_full_rejects = 0;
   int                       n_empty_rejects = 0;

   // Directed part. Dequeue once right after reset, fill with the extremes and
   // duplicates, overflow once, drain to empty, underflow once, then a short
   // mixed tail. Sorted content when full: MIN, MIN, -1, 0, 0, 1, MAX, MAX.
   dir_row_type directed_rows [23] = '{
      '{CMD_DEQ, 32'sd0,  1'b1, '{STATUS_EMPTY, 32'sd0, 4'd0, 1'b1, 1'b0}}, // empty after reset
      '{CMD_ENQ, KEY_MAX, 1'b0, '0},
      '{CMD_ENQ, KEY_MIN, 1'b0, '0},
      '{CMD_ENQ, 32'sd0,  1'b0, '0},
      '{CMD_ENQ, -32'sd1, 1'b0, '0},
      '{CMD_ENQ, 32'sd1,  1'b0, '0},
      '{CMD_ENQ, 32'sd0,  1'b0, '0},                                       // equal key
      '{CMD_ENQ, KEY_MIN, 1'b0, '0},                                       // equal extreme
      '{CMD_ENQ, KEY_MAX, 1'b0, '0},                                       // now full
      '{CMD_ENQ, 32'sd5,  1'b1, '{STATUS_FULL, 32'sd0, 4'd8, 1'b0, 1'b1}},  // dropped
      '{CMD_DEQ, 32'sd0,  1'b1, '{STATUS_OK, KEY_MIN, 4'd7, 1'b0, 1'b0}},
      '{CMD_DEQ, -32'sd1, 1'b0, '0},                                       // key ignored
      '{CMD_DEQ, 32'sd0,  1'b0, '0},
      '{CMD_DEQ, 32'sd0,  1'b0, '0},
      '{CMD_DEQ, 32'sd0,  1'b0, '0},
      '{CMD_DEQ, 32'sd0,  1'b0, '0},
      '{CMD_DEQ, 32'sd0,  1'b0, '0},
      '{CMD_DEQ, 32'sd0,  1'b1, '{STATUS_OK, KEY_MAX, 4'd0, 1'b1, 1'b0}},   // last one out
      '{CMD_DEQ, KEY_MAX, 1'b1, '{STATUS_EMPTY, 32'sd0, 4'd0, 1'b1, 1'b0}}, // underflow
      '{CMD_ENQ, -32'sd5, 1'b0, '0},
      '{CMD_ENQ, 32'sd3,  1'b0, '0},
      '{CMD_DEQ, 32'sd0,  1'b0, '0},
      '{CMD_DEQ, 32'sd0,  1'b0, '0}
   };

   sorted_array_priority_queue_core uut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_cmd       (req_cmd),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_out_value (rsp_out_value),
      .rsp_count     (rsp_count),
      .rsp_is_empty  (rsp_is_empty),
      .rsp_is_full   (rsp_is_full)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Applies one accepted command to the predictor and returns its response.
   // Insertion goes in front of the first key >= the new one.
   function automatic rsp_word_type apply_queue_cmd(input logic cmd,
                                                    input logic signed [KEY_W-1:0] key);
      rsp_word_type w;
      int           pos;
      w = '0;
      w.status = STATUS_OK;
      if (cmd == CMD_ENQ) begin
         if (model_fill >= DEPTH) begin
            w.status = STATUS_FULL;
         end else begin
            pos = model_fill;
            for (int i = model_fill - 1; i >= 0; i--)
               if (model_keys[i] >= key) pos = i;
            for (int i = model_fill; i > pos; i--)
               model_keys[i] = model_keys[i - 1];
            model_keys[pos] = key;
            model_fill++;
         end
      end else begin
         if (model_fill == 0) begin
            w.status = STATUS_EMPTY;
         end else begin
            w.out_value = model_keys[0];
            for (int i = 1; i < model_fill; i++)
               model_keys[i - 1] = model_keys[i];
            model_fill--;
         end
      end
      w.count    = COUNT_W'(model_fill);
      w.is_empty = (model_fill == 0);
      w.is_full  = (model_fill >= DEPTH);
      return w;
   endfunction

   // Presents one command word and holds it until accepted (start high, busy
   // low at a rising edge). start is left high so back-to-back words need no
   // second assignment in the same step.
   task automatic issue_word(input logic cmd, input logic signed [KEY_W-1:0] key,
                             input logic typed, input rsp_word_type want);
      rsp_word_type predicted;
      req_cmd   <= cmd;
      req_value <= key;
      start     <= 1'b1;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      predicted = apply_queue_cmd(cmd, key);
      pending_words.push_back(typed ? want : predicted);
      if (cmd == CMD_ENQ) n_enq++;
      else n_deq++;
      if (predicted.status == STATUS_FULL) n_full_rejects++;
      if (predicted.status == STATUS_EMPTY) n_empty_rejects++;
   endtask

   task automatic hold_off(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Key mix: half full-range, a share of small values to force duplicates,
   // and the two extremes.
   function automatic logic signed [KEY_W-1:0] pick_key();
      int small_key;
      small_key = int'($urandom_range(0, 8)) - 4;
      case ($urandom_range(0, 9))
         5, 6, 7: return small_key;
         8:       return KEY_MIN;
         9:       return KEY_MAX;
         default: return $urandom;
      endcase
   endfunction

   // Response checker. The block cannot be stalled, so every strobe is taken
   // at the edge that ends its cycle and matched against the oldest pending word.
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_words.size() == 0) begin
            $error("unexpected response word: status %0d out_value %0d count %0d",
                   rsp_status, rsp_out_value, rsp_count);
            mismatches++;
         end else begin
            want = pending_words.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               mismatches++;
            end
            if (rsp_out_value !== want.out_value) begin
               $error("out_value: expected %0d, got %0d", want.out_value, rsp_out_value);
               mismatches++;
            end
            if (rsp_count !== want.count) begin
               $error("count: expected %0d, got %0d", want.count, rsp_count);
               mismatches++;
            end
            if (rsp_is_empty !== want.is_empty) begin
               $error("is_empty: expected %0d, got %0d", want.is_empty, rsp_is_empty);
               mismatches++;
            end
            if (rsp_is_full !== want.is_full) begin
               $error("is_full: expected %0d, got %0d", want.is_full, rsp_is_full);
               mismatches++;
            end
         end
      end
   end

   initial begin
      traffic_mix_type mix;
      int              mix_left;
      int              enq_pct;
      int              guard;
      mix = MIX_EVEN;
      mix_left = 0;
      enq_pct = 50;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[r]) begin
         if ($urandom_range(0, 3) == 0) hold_off($urandom_range(1, 7));
         issue_word(directed_rows[r].cmd, directed_rows[r].key,
                    directed_rows[r].typed, directed_rows[r].want);
      end

      // Random traffic in segments that lean towards filling, draining or
      // neither, so the queue spends time both full and empty.
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (mix_left == 0) begin
            mix = traffic_mix_type'($urandom_range(0, 2));
            mix_left = $urandom_range(4, 40);
            enq_pct = (mix == MIX_FILL) ? 85 : (mix == MIX_DRAIN) ? 15 : 50;
         end
         mix_left--;
         if (i == PAUSE_AT) begin
            // sender waits until every response word has come back
            start <= 1'b0;
            while (pending_words.size() != 0) @(posedge clock);
            @(posedge clock);
         end else if (i < QUIET_FROM && $urandom_range(0, 7) == 0) begin
            hold_off($urandom_range(1, 7));
         end
         if ($urandom_range(0, 99) < enq_pct)
            issue_word(CMD_ENQ, pick_key(), 1'b0, '0);
         else
            issue_word(CMD_DEQ, $urandom, 1'b0, '0);
      end
      start <= 1'b0;

      // the response word is registered in the core: a short drain window is plenty
      guard = 0;
      while (pending_words.size() != 0 && guard < 100) begin
         @(posedge clock);
         guard++;
      end
      repeat (4) @(posedge clock);
      if (pending_words.size() != 0) begin
         $error("%0d response words never arrived", pending_words.size());
         mismatches++;
      end

      $display("Ran %0d commands: %0d enqueues, %0d dequeues.", n_enq + n_deq, n_enq, n_deq);
      $display("Saw %0d full rejects and %0d empty rejects; %0d mismatches.",
               n_full_rejects, n_empty_rejects, mismatches);
      if (mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #400000;
      $display("Verification failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_array_priority_queue_core.sv
bench/tb_sorted_array_priority_queue_core.sv
